### design/lcgrf_pkg.sv
// Shared types and constants of the LCG random generator with fmix64 output.
package lcgrf_pkg;

	localparam int unsigned ACTION_W   = 2;
	localparam int unsigned WORD_W     = 64;
	localparam int unsigned HALF_W     = 32;
	localparam int unsigned IN_DATA_W  = 128;
	localparam int unsigned OUT_DATA_W = 96;
	localparam int unsigned DIV_CNT_W  = 5;

	localparam logic [WORD_W-1:0] LCG_MULT   = 64'h5851_F42D_4C95_7F2D;
	localparam logic [WORD_W-1:0] GOLDEN_INC = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [WORD_W-1:0] SM_MUL_A   = 64'hBF58_476D_1CE4_E5B9;
	localparam logic [WORD_W-1:0] SM_MUL_B   = 64'h94D0_49BB_1331_11EB;
	localparam logic [WORD_W-1:0] FMIX_MUL_A = 64'hFF51_AFD7_ED55_8CCD;
	localparam logic [WORD_W-1:0] FMIX_MUL_B = 64'hC4CE_B9FE_1A85_EC53;

	typedef enum logic [ACTION_W-1:0] {
		ACT_DRAW64 = 2'd0,
		ACT_DRAW32 = 2'd1,
		ACT_RANGE  = 2'd2,
		ACT_RESEED = 2'd3
	} action_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_DADD,
		S_DX1,
		S_DX2,
		S_RADD,
		S_RX27,
		S_RX31,
		S_DIV,
		S_OUT
	} state_t;

	typedef enum logic [2:0] {
		MS_LCG,
		MS_FA,
		MS_FB,
		MS_SA,
		MS_SB
	} mul_sel_t;

endpackage

### design/lcg_random_with_finalizer_top.sv
// Top level of the LCG random generator with a murmur3 fmix64 output mix.
//
// Usage: one request enters on the s_ group and yields exactly one result on the m_ group.
// s_tuser carries the action (draw 64-bit, draw 32-bit, draw in range, reseed); s_tdata
// carries the seed and the range bounds. m_tdata carries the 64-bit word and the range result.
// All multiplications run on one shared 32x32 multiplier; a 64-bit product modulo 2^64 is
// built from three partial products. The range remainder is a restoring divider that
// retires one bit per cycle. An empty or inverted range skips the draw and goes straight
// to the output state.
// The block takes one request at a time: s_tready is high only while it is idle, so it
// takes no new request before it is through with the last one.
// After reset the block runs a reseed with seed zero on its own, with s_tready low and
// no result produced. Then the generator is in its defined reset state.
// The output register lets a new request be accepted while an earlier result still waits.
// When the receiver stalls and a new result is ready, the block holds that result until the
// output register frees, and accepts nothing meanwhile.
module lcg_random_with_finalizer_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// s_tdata from bit 0: seed_value[63:0], range_low[95:64], range_high[127:96]
	input  logic [lcgrf_pkg::IN_DATA_W-1:0]    s_tdata,
	// s_tuser: action[1:0]
	input  logic [lcgrf_pkg::ACTION_W-1:0]     s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// m_tdata from bit 0: random_word[63:0], range_result[95:64]
	output logic [lcgrf_pkg::OUT_DATA_W-1:0]   m_tdata
);
	import lcgrf_pkg::*;

	// Sequencer state and control registers.
	state_t                st_q, st_d;
	mul_sel_t              sel_q, sel_d;
	logic [1:0]            cnt_q, cnt_d;
	logic                  pass_q, pass_d;
	logic                  init_q, init_d;
	logic [DIV_CNT_W-1:0]  div_cnt_q, div_cnt_d;
	logic                  out_valid_q, out_valid_d;

	// Datapath registers.
	logic [WORD_W-1:0]     v_q, v_d;
	logic [WORD_W-1:0]     lcg_q, lcg_d;
	logic [WORD_W-1:0]     inc_q, inc_d;
	action_t               act_q, act_d;
	logic [HALF_W-1:0]     lo_q, lo_d;
	logic [HALF_W-1:0]     hi_q, hi_d;
	logic [WORD_W-1:0]     prod_q, prod_d;
	logic [WORD_W-1:0]     acc_q, acc_d;
	logic [HALF_W-1:0]     rem_q, rem_d;
	logic [HALF_W-1:0]     top_q, top_d;
	logic [WORD_W-1:0]     out_word_q, out_word_d;
	logic [HALF_W-1:0]     out_range_q, out_range_d;

	// Combinational helpers.
	logic [WORD_W-1:0]     mul_b;
	logic [HALF_W-1:0]     mul_x;
	logic [HALF_W-1:0]     mul_y;
	logic [WORD_W-1:0]     acc_sum;
	logic [WORD_W-1:0]     add_t;
	logic [WORD_W-1:0]     mix_w;
	logic [HALF_W-1:0]     span;
	logic [HALF_W:0]       trial;
	logic [HALF_W-1:0]     s_low;
	logic [HALF_W-1:0]     s_high;
	logic [WORD_W-1:0]     s_seed_full;

	assign s_seed_full = s_tdata[63:0];
	assign s_low       = s_tdata[95:64];
	assign s_high      = s_tdata[127:96];

	assign s_tready = (st_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_range_q, out_word_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_RADD;
			sel_q       <= MS_LCG;
			cnt_q       <= '0;
			pass_q      <= 1'b0;
			init_q      <= 1'b1;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			v_q         <= '0;
		end else begin
			st_q        <= st_d;
			sel_q       <= sel_d;
			cnt_q       <= cnt_d;
			pass_q      <= pass_d;
			init_q      <= init_d;
			div_cnt_q   <= div_cnt_d;
			out_valid_q <= out_valid_d;
			v_q         <= v_d;
		end
	end

	always_ff @(posedge clk) begin
		lcg_q       <= lcg_d;
		inc_q       <= inc_d;
		act_q       <= act_d;
		lo_q        <= lo_d;
		hi_q        <= hi_d;
		prod_q      <= prod_d;
		acc_q       <= acc_d;
		rem_q       <= rem_d;
		top_q       <= top_d;
		out_word_q  <= out_word_d;
		out_range_q <= out_range_d;
	end

	// The shared multiplier: operand A is always the working word, operand B a constant.
	// Partial products in order: lo*lo, lo(A)*hi(B), hi(A)*lo(B).
	always_comb begin
		case (sel_q)
			MS_LCG:  mul_b = LCG_MULT;
			MS_FA:   mul_b = FMIX_MUL_A;
			MS_FB:   mul_b = FMIX_MUL_B;
			MS_SA:   mul_b = SM_MUL_A;
			MS_SB:   mul_b = SM_MUL_B;
			default: mul_b = LCG_MULT;
		endcase
		case (cnt_q)
			2'd0:    begin mul_x = v_q[HALF_W-1:0];      mul_y = mul_b[HALF_W-1:0];      end
			2'd1:    begin mul_x = v_q[HALF_W-1:0];      mul_y = mul_b[WORD_W-1:HALF_W]; end
			default: begin mul_x = v_q[WORD_W-1:HALF_W]; mul_y = mul_b[HALF_W-1:0];      end
		endcase
	end

	assign acc_sum = acc_q + {prod_q[HALF_W-1:0], {HALF_W{1'b0}}};
	assign span    = hi_q - lo_q;
	assign trial   = {rem_q, top_q[HALF_W-1]};

	always_comb begin
		st_d        = st_q;
		sel_d       = sel_q;
		cnt_d       = cnt_q;
		pass_d      = pass_q;
		init_d      = init_q;
		div_cnt_d   = div_cnt_q;
		out_valid_d = out_valid_q;
		v_d         = v_q;
		lcg_d       = lcg_q;
		inc_d       = inc_q;
		act_d       = act_q;
		lo_d        = lo_q;
		hi_d        = hi_q;
		prod_d      = {{HALF_W{1'b0}}, mul_x} * {{HALF_W{1'b0}}, mul_y};
		acc_d       = acc_q;
		rem_d       = rem_q;
		top_d       = top_q;
		out_word_d  = out_word_q;
		out_range_d = out_range_q;
		add_t       = '0;
		mix_w       = '0;

		if (out_valid_q && m_tready) begin
			out_valid_d = 1'b0;
		end

		case (st_q)
			S_IDLE: begin
				if (s_tvalid) begin
					act_d = action_t'(s_tuser);
					lo_d  = s_low;
					hi_d  = s_high;
					case (action_t'(s_tuser))
						ACT_RESEED: begin
							v_d    = s_seed_full;
							pass_d = 1'b0;
							st_d   = S_RADD;
						end
						ACT_RANGE: begin
							if ($signed(s_high) <= $signed(s_low)) begin
								// Empty or inverted range: the result is the lower bound.
								rem_d = '0;
								st_d  = S_OUT;
							end else begin
								v_d   = lcg_q;
								sel_d = MS_LCG;
								cnt_d = '0;
								st_d  = S_MUL;
							end
						end
						default: begin
							v_d   = lcg_q;
							sel_d = MS_LCG;
							cnt_d = '0;
							st_d  = S_MUL;
						end
					endcase
				end
			end
			S_MUL: begin
				cnt_d = cnt_q + 2'd1;
				if (cnt_q == 2'd1) begin
					acc_d = prod_q;
				end else if (cnt_q == 2'd2) begin
					acc_d = acc_sum;
				end else if (cnt_q == 2'd3) begin
					v_d   = acc_sum;
					cnt_d = '0;
					case (sel_q)
						MS_LCG:  st_d = S_DADD;
						MS_FA:   st_d = S_DX1;
						MS_FB:   st_d = S_DX2;
						MS_SA:   st_d = S_RX27;
						MS_SB:   st_d = S_RX31;
						default: st_d = S_IDLE;
					endcase
				end
			end
			S_DADD: begin
				add_t = v_q + inc_q;
				lcg_d = add_t;
				v_d   = add_t ^ (add_t >> 33);
				sel_d = MS_FA;
				st_d  = S_MUL;
			end
			S_DX1: begin
				v_d   = v_q ^ (v_q >> 33);
				sel_d = MS_FB;
				st_d  = S_MUL;
			end
			S_DX2: begin
				mix_w = v_q ^ (v_q >> 33);
				v_d   = mix_w;
				if (act_q == ACT_RANGE) begin
					top_d     = mix_w[WORD_W-1:HALF_W];
					rem_d     = '0;
					div_cnt_d = '0;
					st_d      = S_DIV;
				end else begin
					st_d = S_OUT;
				end
			end
			S_RADD: begin
				add_t = v_q + GOLDEN_INC;
				v_d   = add_t ^ (add_t >> 30);
				sel_d = MS_SA;
				cnt_d = '0;
				st_d  = S_MUL;
			end
			S_RX27: begin
				v_d   = v_q ^ (v_q >> 27);
				sel_d = MS_SB;
				st_d  = S_MUL;
			end
			S_RX31: begin
				mix_w = v_q ^ (v_q >> 31);
				if (!pass_q) begin
					// First pass done: this is the new state, and it seeds the second pass.
					lcg_d  = mix_w;
					v_d    = mix_w;
					pass_d = 1'b1;
					st_d   = S_RADD;
				end else begin
					inc_d  = mix_w | 64'd1;
					pass_d = 1'b0;
					if (init_q) begin
						init_d = 1'b0;
						st_d   = S_IDLE;
					end else begin
						st_d = S_OUT;
					end
				end
			end
			S_DIV: begin
				// One restoring step: shift in the next dividend bit, subtract if it fits.
				if (trial >= {1'b0, span}) begin
					rem_d = HALF_W'(trial - {1'b0, span});
				end else begin
					rem_d = trial[HALF_W-1:0];
				end
				top_d     = top_q << 1;
				div_cnt_d = div_cnt_q + 1'b1;
				if (div_cnt_q == {DIV_CNT_W{1'b1}}) begin
					st_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!out_valid_q || m_tready) begin
					out_valid_d = 1'b1;
					case (act_q)
						ACT_DRAW64: begin
							out_word_d  = v_q;
							out_range_d = '0;
						end
						ACT_DRAW32: begin
							out_word_d  = {{HALF_W{1'b0}}, v_q[WORD_W-1:HALF_W]};
							out_range_d = '0;
						end
						ACT_RANGE: begin
							out_word_d  = '0;
							out_range_d = lo_q + rem_q;
						end
						default: begin
							out_word_d  = '0;
							out_range_d = '0;
						end
					endcase
					st_d = S_IDLE;
				end
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase
	end

endmodule

### dv/tb_top.sv
// Self-checking testbench for the LCG random generator with the fmix64 output mix.
module tb_top;
	import lcgrf_pkg::*;

	// One request as offered on the slave side.
	typedef struct packed {
		action_t           act;
		logic [WORD_W-1:0] seed;
		logic [HALF_W-1:0] lo;
		logic [HALF_W-1:0] hi;
	} gen_req_t;

	// One result as seen on the master side, in m_tdata order from the top bit down.
	typedef struct packed {
		logic [HALF_W-1:0] rng;
		logic [WORD_W-1:0] word;
	} gen_result_t;

	localparam int DIRECTED_MAX = 32;
	localparam int RANDOM_REQS  = 1040;
	// The last requests run with no random send gaps and no receiver stalls.
	localparam int QUIET_TAIL   = 150;
	// The receiver holds off once for this many cycles after this many results.
	localparam int LONG_HOLD_AT = 300;
	localparam int LONG_HOLD    = 400;
	// The longest latency is a range draw; the drain waits longer than that.
	localparam int DRAIN_CYCLES = 64;
	// Cycles without any handshake before the run is given up.
	localparam int STALL_LIMIT  = 4000;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic [ACTION_W-1:0]   s_tuser  = ACT_DRAW64;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	lcg_random_with_finalizer_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Requests still to be offered, and results predicted but not yet seen.
	gen_req_t    pending_reqs[$];
	gen_result_t expected_out[$];

	// Private copy of the generator: LCG state and odd stream increment.
	logic [WORD_W-1:0] gen_state;
	logic [WORD_W-1:0] gen_inc;

	int total_reqs  = 0;
	int sent_cnt    = 0;
	int rcv_cnt     = 0;
	int err_cnt     = 0;
	int empty_cnt   = 0;
	int idle_cycles = 0;
	int act_cnt[4];

	gen_req_t cur_req;
	int       send_gap  = 0;
	int       hold_left = 0;
	bit       long_done = 1'b0;

	// The seed scrambler used by a reseed.
	function automatic logic [WORD_W-1:0] smix64(input logic [WORD_W-1:0] x);
		logic [WORD_W-1:0] v;
		v = x + GOLDEN_INC;
		v = (v ^ (v >> 30)) * SM_MUL_A;
		v = (v ^ (v >> 27)) * SM_MUL_B;
		return v ^ (v >> 31);
	endfunction

	function automatic void reseed_gen(input logic [WORD_W-1:0] seed);
		gen_state = smix64(seed);
		gen_inc   = smix64(gen_state) | 64'd1;
	endfunction

	// Advances the LCG and returns the fmix64 mix of the new state.
	function automatic logic [WORD_W-1:0] next_draw();
		logic [WORD_W-1:0] v;
		gen_state = gen_state * LCG_MULT + gen_inc;
		v = gen_state;
		v = v ^ (v >> 33);
		v = v * FMIX_MUL_A;
		v = v ^ (v >> 33);
		v = v * FMIX_MUL_B;
		return v ^ (v >> 33);
	endfunction

	// Works out the result of one accepted request and updates the generator copy.
	function automatic gen_result_t predict_result(input gen_req_t r);
		gen_result_t       res;
		logic [WORD_W-1:0] mix;
		logic [HALF_W-1:0] span;
		logic [HALF_W-1:0] top;
		res = '0;
		case (r.act)
			ACT_DRAW64: begin
				res.word = next_draw();
			end
			ACT_DRAW32: begin
				mix      = next_draw();
				res.word = {32'd0, mix[63:32]};
			end
			ACT_RANGE: begin
				// An empty or inverted range returns the low bound and leaves the state alone.
				if ($signed(r.hi) <= $signed(r.lo)) begin
					res.rng = r.lo;
				end else begin
					span    = r.hi - r.lo;
					mix     = next_draw();
					top     = mix[63:32];
					res.rng = r.lo + (top % span);
				end
			end
			default: begin
				reseed_gen(r.seed);
			end
		endcase
		return res;
	endfunction

	function automatic gen_req_t make_req(input action_t act, input logic [WORD_W-1:0] seed,
			input logic [HALF_W-1:0] lo, input logic [HALF_W-1:0] hi);
		gen_req_t r;
		r.act  = act;
		r.seed = seed;
		r.lo   = lo;
		r.hi   = hi;
		return r;
	endfunction

	// Random request: unused fields always carry random bits; range bounds come in
	// several shapes so that narrow, wide, empty and inverted ranges all show up.
	function automatic gen_req_t rand_req();
		gen_req_t r;
		int       pick;
		r.seed = {$urandom, $urandom};
		r.lo   = $urandom;
		r.hi   = $urandom;
		pick   = $urandom_range(0, 99);
		if (pick < 28) begin
			r.act = ACT_DRAW64;
		end else if (pick < 52) begin
			r.act = ACT_DRAW32;
		end else if (pick < 90) begin
			r.act = ACT_RANGE;
			case ($urandom_range(0, 9))
				0, 1, 2, 3: r.hi = r.lo + $urandom_range(1, 1000);
				7:          r.hi = r.lo;
				8:          if ($signed(r.hi) > $signed(r.lo)) {r.lo, r.hi} = {r.hi, r.lo};
				9:          r.hi = r.lo + (32'd1 << $urandom_range(0, 31));
				default:    ;
			endcase
		end else begin
			r.act = ACT_RESEED;
			if ($urandom_range(0, 3) == 0) r.seed = $urandom_range(0, 15);
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		err_cnt++;
	endtask

	// Driver: offers pending requests, holds a request until it is taken, and predicts
	// the result of each request at the edge where it is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= ACT_DRAW64;
			send_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_out.push_back(predict_result(cur_req));
				act_cnt[cur_req.act]++;
				if (cur_req.act == ACT_RANGE && $signed(cur_req.hi) <= $signed(cur_req.lo))
					empty_cnt++;
				sent_cnt++;
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					cur_req = pending_reqs.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= cur_req.act;
					s_tdata  <= {cur_req.hi, cur_req.lo, cur_req.seed};
					// A burst of idle cycles may follow this request, except near the end.
					if (sent_cnt < total_reqs - QUIET_TAIL && $urandom_range(0, 7) == 0)
						send_gap = $urandom_range(1, 19);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result against the oldest prediction and drives m_tready,
	// with random stall bursts and one long hold-off that backs the block up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_out.size() == 0) begin
					report_mismatch($sformatf("result with nothing expected: %h", m_tdata));
				end else begin
					gen_result_t want;
					want = expected_out.pop_front();
					if (m_tdata[63:0] !== want.word)
						report_mismatch($sformatf("random_word got %h want %h",
							m_tdata[63:0], want.word));
					if (m_tdata[95:64] !== want.rng)
						report_mismatch($sformatf("range_result got %h want %h",
							m_tdata[95:64], want.rng));
				end
				rcv_cnt++;
			end
			if (!long_done && rcv_cnt >= LONG_HOLD_AT) begin
				long_done = 1'b1;
				hold_left = LONG_HOLD - 1;
				m_tready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (rcv_cnt < total_reqs - QUIET_TAIL && $urandom_range(0, 9) == 0) begin
				hold_left = $urandom_range(1, 19) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog: counts cycles in which neither side completes a handshake.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		bit timed_out;
		foreach (act_cnt[i]) act_cnt[i] = 0;
		// The generator comes out of reset as if reseeded with zero.
		reseed_gen(64'd0);

		// Directed part. The first draws show the reset state of the generator.
		pending_reqs.push_back(make_req(ACT_DRAW64, '1, '1, '1));
		pending_reqs.push_back(make_req(ACT_DRAW32, '0, '0, '0));
		// Widest span, narrowest span, and spans around zero.
		pending_reqs.push_back(make_req(ACT_RANGE, '1, 32'h8000_0000, 32'h7FFF_FFFF));
		pending_reqs.push_back(make_req(ACT_RANGE, '0, 32'h8000_0000, 32'h8000_0001));
		pending_reqs.push_back(make_req(ACT_RANGE, '0, 32'h0000_0000, 32'h0000_0001));
		pending_reqs.push_back(make_req(ACT_RANGE, '0, 32'hFFFF_FFFB, 32'h0000_0005));
		pending_reqs.push_back(make_req(ACT_RANGE, '0, 32'hFFFF_FFFF, 32'h0000_0000));
		pending_reqs.push_back(make_req(ACT_RANGE, '0, 32'h7FFF_FFFE, 32'h7FFF_FFFF));
		// Empty and inverted ranges, including the extreme bounds.
		pending_reqs.push_back(make_req(ACT_RANGE, '0, 32'h0000_0007, 32'h0000_0007));
		pending_reqs.push_back(make_req(ACT_RANGE, '1, 32'h7FFF_FFFF, 32'h8000_0000));
		pending_reqs.push_back(make_req(ACT_RANGE, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		pending_reqs.push_back(make_req(ACT_RANGE, '0, 32'h8000_0000, 32'h8000_0000));
		pending_reqs.push_back(make_req(ACT_DRAW64, '0, '0, '0));
		// Reseeds with extreme and small seeds, two of them back to back, the others each followed by a draw.
		pending_reqs.push_back(make_req(ACT_RESEED, '0, '1, '1));
		pending_reqs.push_back(make_req(ACT_DRAW64, '0, '0, '0));
		pending_reqs.push_back(make_req(ACT_RESEED, '1, '0, '0));
		pending_reqs.push_back(make_req(ACT_DRAW32, '1, '1, '1));
		pending_reqs.push_back(make_req(ACT_RESEED, 64'h8000_0000_0000_0000, '0, '0));
		pending_reqs.push_back(make_req(ACT_RANGE, '0, 32'h8000_0000, 32'h7FFF_FFFF));
		pending_reqs.push_back(make_req(ACT_RESEED, 64'd1, '0, '0));
		pending_reqs.push_back(make_req(ACT_RESEED, 64'd2, '0, '0));
		pending_reqs.push_back(make_req(ACT_DRAW64, '0, '0, '0));
		pending_reqs.push_back(make_req(ACT_DRAW32, '0, '0, '0));
		if (pending_reqs.size() > DIRECTED_MAX)
			report_mismatch("directed list too long");

		repeat (RANDOM_REQS) pending_reqs.push_back(rand_req());
		total_reqs = pending_reqs.size();

		// Reset once; the block then runs its own seed-zero reseed before it takes requests.
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		wait ((sent_cnt == total_reqs && rcv_cnt == total_reqs) || idle_cycles >= STALL_LIMIT);
		timed_out = !(sent_cnt == total_reqs && rcv_cnt == total_reqs);
		if (timed_out) begin
			$display("Timeout: %0d of %0d requests sent, %0d results seen",
				sent_cnt, total_reqs, rcv_cnt);
			$display("*** FAILED ***");
			$finish;
		end else begin
			// Let any stray result show up before the final verdict.
			repeat (DRAIN_CYCLES) @(posedge clk);
			if (expected_out.size() != 0)
				report_mismatch($sformatf("%0d results never arrived", expected_out.size()));
			$display("Covered %0d requests: %0d draw64, %0d draw32, %0d range (%0d empty), %0d reseed",
				total_reqs, act_cnt[ACT_DRAW64], act_cnt[ACT_DRAW32], act_cnt[ACT_RANGE],
				empty_cnt, act_cnt[ACT_RESEED]);
			$display("Checked %0d results under random stalls on both sides, %0d errors",
				rcv_cnt, err_cnt);
			if (err_cnt == 0)
				$display("*** PASSED ***");
			else
				$display("*** FAILED ***");
			$finish;
		end
	end

endmodule
